// File: src/kne_pkg.sv
// Keypad numeric entry: shared types, codes and the key table.
// No dependencies; used by the interfaces, kne_step and the top level.
package kne_pkg;

  localparam int unsigned VALUE_W     = 30;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 4;

  // Highest digit count the entry field supports
  localparam logic [COUNT_W-1:0] MAX_DIGIT_LIMIT  = COUNT_W'(9);
  localparam logic [COUNT_W-1:0] MAX_DIGITS_RESET = COUNT_W'(4);

  // 2^35 / 10 rounded up; exact divide by ten for any value below 2^32
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SHIFT = 35;

  localparam logic [CHAR_W-1:0] KEY_CANCEL = CHAR_W'(8'h63); // 'c'
  localparam logic [CHAR_W-1:0] KEY_DEL    = CHAR_W'(8'h44); // 'D'
  localparam logic [CHAR_W-1:0] KEY_ENTER  = CHAR_W'(8'h3D); // '='
  localparam logic [CHAR_W-1:0] KEY_MASK   = CHAR_W'(8'h2A); // '*'
  localparam logic [CHAR_W-1:0] KEY_ZERO   = CHAR_W'(8'h30); // '0'
  localparam logic [CHAR_W-1:0] KEY_NINE   = CHAR_W'(8'h39); // '9'

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_ADDED   = 3'd1,
    ST_ERASED  = 3'd2,
    ST_CANCEL  = 3'd3,
    ST_DONE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_SHOW  = 2'd1,
    ECHO_ERASE = 2'd2
  } echo_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DIGITS = 2'd0,
    CFG_MASK_ECHO  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [COUNT_W-1:0] max_digits;
    logic               mask_echo;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  key_char;
    status_e            status;
    logic [VALUE_W-1:0] entry_value;
    logic [COUNT_W-1:0] digit_count;
    echo_e              echo_action;
    logic [CHAR_W-1:0]  echo_char;
  } res_t;

  // 4x4 matrix legend, row-major
  function automatic logic [CHAR_W-1:0] key_lookup(input logic [1:0] row,
                                                   input logic [1:0] col);
    logic [7:0] c;
    unique case ({row, col})
      4'h0: c = 8'h31; // '1'
      4'h1: c = 8'h32; // '2'
      4'h2: c = 8'h33; // '3'
      4'h3: c = 8'h41; // 'A'
      4'h4: c = 8'h34; // '4'
      4'h5: c = 8'h35; // '5'
      4'h6: c = 8'h36; // '6'
      4'h7: c = 8'h42; // 'B'
      4'h8: c = 8'h37; // '7'
      4'h9: c = 8'h38; // '8'
      4'hA: c = 8'h39; // '9'
      4'hB: c = 8'h43; // 'C'
      4'hC: c = 8'h63; // 'c'
      4'hD: c = 8'h30; // '0'
      4'hE: c = 8'h3D; // '='
      4'hF: c = 8'h44; // 'D'
      default: c = 8'h00;
    endcase
    return c[CHAR_W-1:0];
  endfunction

endpackage

// File: src/kne_if.sv
// Keypad numeric entry: valid/ready channel interfaces (key, result, config).
// Depends on kne_pkg for field widths.
interface kne_key_if;
  import kne_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] key_row;
  logic [1:0] key_col;
  modport source (output valid, key_row, key_col, input ready);
  modport sink   (input valid, key_row, key_col, output ready);
endinterface

interface kne_res_if;
  import kne_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  key_char;
  logic [2:0]         status;
  logic [VALUE_W-1:0] entry_value;
  logic [COUNT_W-1:0] digit_count;
  logic [1:0]         echo_action;
  logic [CHAR_W-1:0]  echo_char;
  modport source (output valid, key_char, status, entry_value, digit_count,
                         echo_action, echo_char,
                  input  ready);
  modport sink   (input  valid, key_char, status, entry_value, digit_count,
                         echo_action, echo_char,
                  output ready);
endinterface

interface kne_cfg_if;
  import kne_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/kne_step.sv
// Keypad numeric entry: single-pass decode of one key press and the entry update.
// Depends on kne_pkg (key table, codes, types).
module kne_step
  import kne_pkg::*;
(
  input  logic [1:0] key_row_i,
  input  logic [1:0] key_col_i,
  input  cfg_t       cfg_i,
  input  entry_t     entry_i,
  output entry_t     entry_o,
  output res_t       res_o
);

  logic [CHAR_W-1:0]  key;
  logic [COUNT_W-1:0] limit;
  logic               full;
  logic               is_digit;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] value_x10;
  logic [61:0]        div_prod;
  logic [VALUE_W-1:0] value_div10;
  entry_t             upd;
  status_e            status;
  echo_e              action;
  logic [CHAR_W-1:0]  echo;

  assign key      = key_lookup(key_row_i, key_col_i);
  assign limit    = (cfg_i.max_digits > MAX_DIGIT_LIMIT) ? MAX_DIGIT_LIMIT : cfg_i.max_digits;
  assign full     = entry_i.count >= limit;
  assign is_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
  assign digit    = 4'(key - KEY_ZERO);

  // x10 as shift-add, /10 as reciprocal multiply
  assign value_x10   = (entry_i.value << 3) + (entry_i.value << 1);
  assign div_prod    = 62'(entry_i.value) * 62'(RECIP10);
  assign value_div10 = VALUE_W'(div_prod[61:RECIP10_SHIFT]);

  always_comb begin
    upd    = entry_i;
    status = ST_IGNORED;
    action = ECHO_NONE;
    echo   = '0;
    priority if (key == KEY_CANCEL) begin
      status = ST_CANCEL;
      upd    = '0;
    end else if (key == KEY_DEL) begin
      if (entry_i.count != '0) begin
        upd.count = entry_i.count - COUNT_W'(1);
        upd.value = value_div10;
        status    = ST_ERASED;
        action    = ECHO_ERASE;
      end
    end else if (!full) begin
      if (is_digit) begin
        upd.value = value_x10 + VALUE_W'(digit);
        upd.count = entry_i.count + COUNT_W'(1);
        status    = ST_ADDED;
        action    = ECHO_SHOW;
        echo      = cfg_i.mask_echo ? KEY_MASK : key;
      end
    end else if (key == KEY_ENTER) begin
      status = ST_DONE;
    end
  end

  always_comb begin
    res_o.key_char    = key;
    res_o.status      = status;
    res_o.entry_value = upd.value;
    res_o.digit_count = upd.count;
    res_o.echo_action = action;
    res_o.echo_char   = echo;
    // finished entry is reported once, then the field starts afresh
    entry_o = (status == ST_DONE) ? '0 : upd;
  end

endmodule

// File: src/keypad_numeric_entry_unit.sv
// Keypad numeric entry top level: input register, step logic, result register.
// Depends on kne_pkg, kne_if (channel interfaces) and kne_step.

// Decimal entry from a 4x4 keypad: each accepted key transaction yields exactly one
// result. Sustained rate is one key per clock while results are taken; each key passes
// through the key register and then the result register around the one-pass
// step logic (shift-add times ten, reciprocal multiply for divide by ten). Both sides
// are decoupled, so a key is taken while an earlier result still waits. Configuration
// (index 0 max_digits, index 1 mask_echo) is always ready and should only be written
// while no key is in flight.
module keypad_numeric_entry_unit
  import kne_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  kne_key_if.sink   key_i,
  kne_cfg_if.sink   cfg_i,
  kne_res_if.source res_o
);

  logic       in_vld_q;
  logic [1:0] key_row_q;
  logic [1:0] key_col_q;
  logic       out_vld_q;
  res_t       res_q;
  res_t       res_d;
  entry_t     entry_q;
  entry_t     entry_d;
  cfg_t       cfg_q;
  logic       advance;
  logic       key_take;

  assign advance   = in_vld_q && (!out_vld_q || res_o.ready);
  assign key_i.ready = !in_vld_q || advance;
  assign key_take  = key_i.valid && key_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (key_i.ready) begin
      in_vld_q <= key_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_take) begin
      key_row_q <= key_i.key_row;
      key_col_q <= key_i.key_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_digits <= MAX_DIGITS_RESET;
      cfg_q.mask_echo  <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAX_DIGITS: cfg_q.max_digits <= cfg_i.data;
        CFG_MASK_ECHO:  cfg_q.mask_echo  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  kne_step u_step (
    .key_row_i (key_row_q),
    .key_col_i (key_col_q),
    .cfg_i     (cfg_q),
    .entry_i   (entry_q),
    .entry_o   (entry_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (advance) begin
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.key_char    = res_q.key_char;
  assign res_o.status      = res_q.status;
  assign res_o.entry_value = res_q.entry_value;
  assign res_o.digit_count = res_q.digit_count;
  assign res_o.echo_action = res_q.echo_action;
  assign res_o.echo_char   = res_q.echo_char;

`ifndef NO_ASSERTIONS
  a_count_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_q.count <= MAX_DIGIT_LIMIT)
    else $error("digit count above limit");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_q.count == '0) |-> (entry_q.value == '0))
    else $error("empty entry holds a nonzero value");

  a_done_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (res_d.status == ST_DONE || res_d.status == ST_CANCEL))
      |=> (entry_q == '0))
    else $error("entry not cleared after done or cancel");

  a_take_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_take |=> in_vld_q)
    else $error("accepted key not held in key register");
`endif

endmodule

// File: tb/tb_keypad_numeric_entry_unit.sv
`timescale 1ns / 100ps
// Testbench for keypad_numeric_entry_unit: key presses in, one result per press checked
// field by field against a behavioural model of the entry logic.
// Depends on kne_pkg, the channel interfaces in kne_if and the top level.
module tb_keypad_numeric_entry_unit;
  import kne_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;

  // key matrix positions as {row, col}
  localparam logic [3:0] POS_A      = 4'h3;
  localparam logic [3:0] POS_B      = 4'h7;
  localparam logic [3:0] POS_C      = 4'hB;
  localparam logic [3:0] POS_CANCEL = 4'hC;
  localparam logic [3:0] POS_ZERO   = 4'hD;
  localparam logic [3:0] POS_ENTER  = 4'hE;
  localparam logic [3:0] POS_DEL    = 4'hF;

  // legend, row-major, one byte per key
  localparam logic [8*16-1:0] LEGEND = "123A456B789Cc0=D";

  logic clk_i;
  logic rst_ni;

  kne_key_if key_if ();
  kne_cfg_if cfg_if ();
  kne_res_if res_if ();

  keypad_numeric_entry_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // model state and register copies
  logic [VALUE_W-1:0] entry_value_q = '0;
  logic [COUNT_W-1:0] entry_count_q = '0;
  logic [COUNT_W-1:0] max_digits_q  = MAX_DIGITS_RESET;
  logic               mask_echo_q   = 1'b0;

  res_t        press_results_q[$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  int unsigned key_presses  = 0;
  bit          no_idle      = 1'b0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic res_t predict_press(input logic [3:0] pos);
    res_t               r;
    logic [7:0]         byte_q;
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] lim;
    logic               full;
    byte_q = LEGEND[8*(15-pos) +: 8];
    ch     = byte_q[CHAR_W-1:0];
    lim    = (max_digits_q > MAX_DIGIT_LIMIT) ? MAX_DIGIT_LIMIT : max_digits_q;
    full   = (entry_count_q >= lim);
    r             = '0;
    r.key_char    = ch;
    r.status      = ST_IGNORED;
    r.echo_action = ECHO_NONE;
    if (ch == KEY_CANCEL) begin
      r.status      = ST_CANCEL;
      entry_value_q = '0;
      entry_count_q = '0;
    end else if (ch == KEY_DEL) begin
      if (entry_count_q != 0) begin
        entry_count_q = entry_count_q - 1'b1;
        entry_value_q = entry_value_q / 30'd10;
        r.status      = ST_ERASED;
        r.echo_action = ECHO_ERASE;
      end
    end else if (!full) begin
      if (ch >= KEY_ZERO && ch <= KEY_NINE) begin
        entry_value_q = entry_value_q * 30'd10 + 30'(ch - KEY_ZERO);
        entry_count_q = entry_count_q + 1'b1;
        r.status      = ST_ADDED;
        r.echo_action = ECHO_SHOW;
        r.echo_char   = mask_echo_q ? KEY_MASK : ch;
      end
    end else if (ch == KEY_ENTER) begin
      r.status = ST_DONE;
    end
    r.entry_value = entry_value_q;
    r.digit_count = entry_count_q;
    if (r.status == ST_DONE) begin
      entry_value_q = '0;
      entry_count_q = '0;
    end
    return r;
  endfunction

  function automatic logic [3:0] digit_pos(input int unsigned d);
    logic [1:0] row;
    logic [1:0] col;
    if (d == 0) return POS_ZERO;
    row = 2'((d - 1) / 3);
    col = 2'((d - 1) % 3);
    return {row, col};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Called at a falling edge or just after an accepting rising edge; returns right
  // after the key transaction, leaving valid high for a back-to-back press.
  task automatic press_key(input logic [3:0] pos);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      key_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    key_if.valid   = 1'b1;
    key_if.key_row = pos[3:2];
    key_if.key_col = pos[1:0];
    do @(posedge clk_i); while (!key_if.ready);
    press_results_q.push_back(predict_press(pos));
    key_presses++;
  endtask

  // Drop the key channel and let every pending result drain
  task automatic wait_idle();
    @(negedge clk_i);
    key_if.valid = 1'b0;
    while (press_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_MAX_DIGITS: max_digits_q = data;
      CFG_MASK_ECHO:  mask_echo_q  = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Reset limit of four: ignored keys, erase, cancel, fill, digit on full, enter
  task automatic test_default_entry();
    press_key(POS_DEL);
    press_key(POS_A);
    press_key(POS_B);
    press_key(POS_C);
    press_key(POS_ENTER);
    press_key(digit_pos(4));
    press_key(digit_pos(8));
    press_key(POS_DEL);
    press_key(POS_CANCEL);
    press_key(digit_pos(9));
    press_key(digit_pos(0));
    press_key(digit_pos(5));
    press_key(digit_pos(6));
    press_key(digit_pos(7));
    press_key(POS_ENTER);
    wait_idle();
  endtask

  // Zero limit, limit above nine with masked echo, then limit lowered under the count
  task automatic test_limit_extremes();
    write_register(CFG_MAX_DIGITS, 4'd0);
    press_key(digit_pos(1));
    press_key(POS_ENTER);
    wait_idle();
    write_register(CFG_MAX_DIGITS, 4'd15);
    write_register(CFG_MASK_ECHO, 4'd1);
    repeat (9) press_key(digit_pos(9));
    wait_idle();
    write_register(CFG_MAX_DIGITS, 4'd1);
    press_key(digit_pos(0));
    press_key(POS_DEL);
    press_key(POS_ENTER);
    wait_idle();
  endtask

  task automatic enter_random_session();
    logic [COUNT_W-1:0] lim;
    int unsigned        n;
    int unsigned        finish;
    lim = (max_digits_q > MAX_DIGIT_LIMIT) ? MAX_DIGIT_LIMIT : max_digits_q;
    n   = $urandom_range(0, lim + 1);
    for (int unsigned i = 0; i < n; i++) begin
      press_key(digit_pos($urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) press_key(POS_DEL);
    end
    finish = $urandom_range(0, 19);
    if (finish < 13)      press_key(POS_ENTER);
    else if (finish < 16) press_key(POS_CANCEL);
    else if (finish < 18) press_key(4'($urandom_range(0, 15)));
  endtask

  task automatic test_random_sessions();
    int unsigned next_phase;
    int unsigned pick;
    logic [3:0]  limit_data;
    next_phase = key_presses;
    while (key_presses < 730) begin
      if (key_presses >= next_phase) begin
        wait_idle();
        pick = $urandom_range(0, 9);
        case (pick)
          0:       limit_data = 4'd0;
          1:       limit_data = 4'd1;
          2:       limit_data = 4'd9;
          3:       limit_data = 4'($urandom_range(10, 15));
          default: limit_data = 4'($urandom_range(1, 9));
        endcase
        write_register(CFG_MAX_DIGITS, limit_data);
        write_register(CFG_MASK_ECHO, 4'($urandom_range(0, 1)));
        no_idle    = ($urandom_range(0, 3) == 0);
        next_phase = key_presses + 70;
      end
      if ($urandom_range(0, 7) == 0) press_key(4'($urandom_range(0, 15)));
      else                           enter_random_session();
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (press_results_q.size() == 0) begin
        report_mismatch("unexpected result, key_char", 32'(res_if.key_char), 32'd0);
      end else begin
        want = press_results_q.pop_front();
        check_field("key_char",    32'(res_if.key_char),    32'(want.key_char));
        check_field("status",      32'(res_if.status),      32'(want.status));
        check_field("entry_value", 32'(res_if.entry_value), 32'(want.entry_value));
        check_field("digit_count", 32'(res_if.digit_count), 32'(want.digit_count));
        check_field("echo_action", 32'(res_if.echo_action), 32'(want.echo_action));
        check_field("echo_char",   32'(res_if.echo_char),   32'(want.echo_char));
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 5);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((key_if.valid && key_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    key_if.valid   = 1'b0;
    key_if.key_row = '0;
    key_if.key_col = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_MAX_DIGITS;
    cfg_if.data    = '0;
    res_if.ready   = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_entry();
    test_limit_extremes();
    test_random_sessions();

    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: keypad_numeric_entry_unit.f
src/kne_pkg.sv
src/kne_if.sv
src/kne_step.sv
src/keypad_numeric_entry_unit.sv
tb/tb_keypad_numeric_entry_unit.sv
